FILE: rtl/aesbm_pkg.sv
// types, tables and round functions shared by the aes-128 block mode engine
package aesbm_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_LOAD,
      ST_ROUND,
      ST_FINISH
   } state_type;

   localparam logic [2:0] MODE_ECB = 3'd0;
   localparam logic [2:0] MODE_CBC = 3'd1;
   localparam logic [2:0] MODE_CFB = 3'd2;
   localparam logic [2:0] MODE_OFB = 3'd3;
   localparam logic [2:0] MODE_CTR = 3'd4;

   localparam logic [2:0] CSR_KEY_HIGH    = 3'd0;
   localparam logic [2:0] CSR_KEY_LOW     = 3'd1;
   localparam logic [2:0] CSR_IV_HIGH     = 3'd2;
   localparam logic [2:0] CSR_IV_LOW      = 3'd3;
   localparam logic [2:0] CSR_BLOCK_MODE  = 3'd4;
   localparam logic [2:0] CSR_DECRYPT_SEL = 3'd5;

   localparam logic [3:0] LAST_ROUND = 4'd10;
   localparam logic [4:0] FULL_COUNT = 5'd16;
   localparam logic [7:0] RCON_FIRST = 8'h01;

   localparam logic [2047:0] SBOX_TABLE = {
      128'h637c777bf26b6fc53001672bfed7ab76,
      128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115,
      128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84,
      128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8,
      128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973,
      128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479,
      128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
      128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df,
      128'h8ca1890dbfe6426841992d0fb054bb16
   };

   localparam logic [2047:0] ISBOX_TABLE = {
      128'h52096ad53036a538bf40a39e81f3d7fb,
      128'h7ce339829b2fff87348e4344c4dee9cb,
      128'h547b9432a6c2233dee4c950b42fac34e,
      128'h082ea16628d924b2765ba2496d8bd125,
      128'h72f8f66486689816d4a45ccc5d65b692,
      128'h6c704850fdedb9da5e154657a78d9d84,
      128'h90d8ab008cbcd30af7e45805b8b34506,
      128'hd02c1e8fca3f0f02c1afbd0301138a6b,
      128'h3a9111414f67dcea97f2cfcef0b4e673,
      128'h96ac7422e7ad3585e2f937e81c75df6e,
      128'h47f11a711d29c5896fb7620eaa18be1b,
      128'hfc563e4bc6d279209adbc0fe78cd5af4,
      128'h1fdda8338807c731b11210592780ec5f,
      128'h60517fa919b54a0d2de57a9f93c99cef,
      128'ha0e03b4dae2af5b0c8ebbb3c83539961,
      128'h172b047eba77d626e169146355210c7d
   };

   function automatic logic [7:0] sbox(input logic [7:0] x);
      return SBOX_TABLE[11'(11'd2047 - {x, 3'b000}) -: 8];
   endfunction

   function automatic logic [7:0] isbox(input logic [7:0] x);
      return ISBOX_TABLE[11'(11'd2047 - {x, 3'b000}) -: 8];
   endfunction

   function automatic logic [7:0] xt(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] b);
      logic [7:0] r;
      logic [7:0] p;
      r = 8'h00;
      p = a;
      for (int i = 0; i < 4; i++) begin
         if (b[i]) begin
            r = r ^ p;
         end
         p = xt(p);
      end
      return r;
   endfunction

   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] t;
      t = '0;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            t[127 - 8 * (r + 4 * c) -: 8] = sbox(s[127 - 8 * (r + 4 * ((c + r) & 3)) -: 8]);
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
      logic [127:0] t;
      t = '0;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            t[127 - 8 * (r + 4 * c) -: 8] =
               isbox(s[127 - 8 * (r + 4 * ((c - r + 4) & 3)) -: 8]);
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
      logic [127:0] t;
      logic [7:0]   a0, a1, a2, a3;
      logic [3:0]   m0, m1, m2, m3;
      t  = '0;
      m0 = inv ? 4'd14 : 4'd2;
      m1 = inv ? 4'd11 : 4'd3;
      m2 = inv ? 4'd13 : 4'd1;
      m3 = inv ? 4'd9  : 4'd1;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127 - 32 * c -: 8];
         a1 = s[119 - 32 * c -: 8];
         a2 = s[111 - 32 * c -: 8];
         a3 = s[103 - 32 * c -: 8];
         t[127 - 32 * c -: 8] = gm(a0, m0) ^ gm(a1, m1) ^ gm(a2, m2) ^ gm(a3, m3);
         t[119 - 32 * c -: 8] = gm(a0, m3) ^ gm(a1, m0) ^ gm(a2, m1) ^ gm(a3, m2);
         t[111 - 32 * c -: 8] = gm(a0, m2) ^ gm(a1, m3) ^ gm(a2, m0) ^ gm(a3, m1);
         t[103 - 32 * c -: 8] = gm(a0, m1) ^ gm(a1, m2) ^ gm(a2, m3) ^ gm(a3, m0);
      end
      return t;
   endfunction

   function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] t, w4, w5, w6, w7;
      t  = {sbox(k[23:16]), sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])} ^ {rc, 24'h000000};
      w4 = k[127:96] ^ t;
      w5 = k[95:64] ^ w4;
      w6 = k[63:32] ^ w5;
      w7 = k[31:0] ^ w6;
      return {w4, w5, w6, w7};
   endfunction

   function automatic logic [127:0] byte_mask(input logic [4:0] cnt);
      logic [127:0] m;
      m = '0;
      for (int i = 0; i < 16; i++) begin
         if (5'(i) < cnt) begin
            m[127 - 8 * i -: 8] = 8'hff;
         end
      end
      return m;
   endfunction

   function automatic logic [127:0] pad_fill(input logic [4:0] cnt);
      logic [127:0] m;
      logic [7:0]   v;
      m = '0;
      v = {3'b000, 5'(FULL_COUNT - cnt)};
      for (int i = 0; i < 16; i++) begin
         if (5'(i) >= cnt) begin
            m[127 - 8 * i -: 8] = v;
         end
      end
      return m;
   endfunction

endpackage

FILE: rtl/aes128_block_modes_core.sv
// aes-128 block engine with ecb, cbc, cfb, ofb and ctr modes and pkcs#7 padding
//
// One shared round unit does one AES round per cycle. A block goes from its
// transfer through a load state, ten rounds (none for an empty CFB, OFB or
// CTR block) and a finish state, then back to idle before the next transfer.
// After reset or a key write the first block also runs the key schedule, one
// round key per cycle. A full last block in ECB or CBC encryption gives a
// second, padding result by another pass from the load state. req_stall is
// high whilst a block is in progress; the result register holds one result.
module aes128_block_modes_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_data_high,
   input  logic [63:0] req_data_low,
   input  logic [4:0]  req_byte_count,
   input  logic        req_first_block,
   input  logic        req_last_block,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_out_high,
   output logic [63:0] rsp_out_low,
   output logic [4:0]  rsp_out_count,
   output logic        rsp_end_of_run,
   output logic        rsp_pad_error,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   aesbm_pkg::state_type state_ff, state_in;

   logic [127:0] key_ff, iv_ff;
   logic [2:0]   mode_reg_ff;
   logic         dec_reg_ff;
   logic         keys_ready_ff, keys_ready_in;
   logic [127:0] rk_ff [11];
   logic [127:0] kexp_ff, kexp_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic [3:0]   rnd_ff, rnd_in;
   logic [127:0] st_ff, st_in;
   logic [127:0] chain_ff, chain_in;
   logic [127:0] data_ff, data_in;
   logic [4:0]   cnt_ff, cnt_in;
   logic         last_ff, last_in;
   logic [2:0]   mode_ff, mode_in;
   logic         dec_ff, dec_in;
   logic         pass2_ff, pass2_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [127:0] rsp_data_ff, rsp_data_in;
   logic [4:0]   rsp_count_ff, rsp_count_in;
   logic         rsp_end_ff, rsp_end_in;
   logic         rsp_err_ff, rsp_err_in;

   logic         req_xfer, rsp_free, aes_dec, stream, blk_mode_enc;
   logic [3:0]   rk_index;
   logic [127:0] rk_sel, round_out, blk, dmask, fin_b, dm;
   logic [7:0]   pad_len;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign stream   = (mode_ff != aesbm_pkg::MODE_ECB) && (mode_ff != aesbm_pkg::MODE_CBC);
   assign aes_dec  = !stream && dec_ff;
   assign blk_mode_enc = !stream && !dec_ff;
   assign rk_index = aes_dec ? 4'(aesbm_pkg::LAST_ROUND - rnd_ff) : rnd_ff;
   assign rk_sel   = rk_ff[rk_index];
   assign dmask    = aesbm_pkg::byte_mask(cnt_ff);
   assign dm       = data_ff & dmask;

   always_comb begin
      if (aes_dec) begin
         round_out = aesbm_pkg::inv_sub_shift(st_ff) ^ rk_sel;
         if (rnd_ff != aesbm_pkg::LAST_ROUND) begin
            round_out = aesbm_pkg::mix(round_out, 1'b1);
         end
      end else begin
         round_out = aesbm_pkg::sub_shift(st_ff);
         if (rnd_ff != aesbm_pkg::LAST_ROUND) begin
            round_out = aesbm_pkg::mix(round_out, 1'b0);
         end
         round_out = round_out ^ rk_sel;
      end
   end

   always_comb begin
      if (pass2_ff) begin
         blk = {16{8'h10}};
      end else if (last_ff) begin
         blk = (data_ff & dmask) | aesbm_pkg::pad_fill(cnt_ff);
      end else begin
         blk = data_ff;
      end
      if (mode_ff == aesbm_pkg::MODE_CBC) begin
         blk = blk ^ chain_ff;
      end
      if (aes_dec) begin
         blk = data_ff;
      end else if (stream) begin
         blk = chain_ff;
      end
   end

   assign fin_b   = st_ff ^ ((mode_ff == aesbm_pkg::MODE_CBC) ? chain_ff : '0);
   assign pad_len = fin_b[7:0];

   always_comb begin
      state_in      = state_ff;
      keys_ready_in = keys_ready_ff;
      kexp_in       = kexp_ff;
      rcon_in       = rcon_ff;
      rnd_in        = rnd_ff;
      st_in         = st_ff;
      chain_in      = chain_ff;
      data_in       = data_ff;
      cnt_in        = cnt_ff;
      last_in       = last_ff;
      mode_in       = mode_ff;
      dec_in        = dec_ff;
      pass2_in      = pass2_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_err_in    = rsp_err_ff;
      req_stall     = (state_ff != aesbm_pkg::ST_IDLE);

      case (state_ff)
         aesbm_pkg::ST_IDLE: begin
            if (req_xfer) begin
               data_in  = {req_data_high, req_data_low};
               cnt_in   = (req_byte_count > aesbm_pkg::FULL_COUNT) ?
                          aesbm_pkg::FULL_COUNT : req_byte_count;
               last_in  = req_last_block;
               mode_in  = (mode_reg_ff > aesbm_pkg::MODE_CTR) ? aesbm_pkg::MODE_ECB : mode_reg_ff;
               dec_in   = dec_reg_ff;
               pass2_in = 1'b0;
               if (req_first_block) begin
                  chain_in = iv_ff;
               end
               if (keys_ready_ff) begin
                  state_in = aesbm_pkg::ST_LOAD;
               end else begin
                  kexp_in  = key_ff;
                  rcon_in  = aesbm_pkg::RCON_FIRST;
                  rnd_in   = 4'd1;
                  state_in = aesbm_pkg::ST_EXPAND;
               end
            end
         end
         aesbm_pkg::ST_EXPAND: begin
            kexp_in = aesbm_pkg::key_step(kexp_ff, rcon_ff);
            rcon_in = aesbm_pkg::xt(rcon_ff);
            rnd_in  = 4'(rnd_ff + 4'd1);
            if (rnd_ff == aesbm_pkg::LAST_ROUND) begin
               keys_ready_in = 1'b1;
               state_in      = aesbm_pkg::ST_LOAD;
            end
         end
         aesbm_pkg::ST_LOAD: begin
            st_in  = blk ^ rk_ff[aes_dec ? aesbm_pkg::LAST_ROUND : 4'd0];
            rnd_in = 4'd1;
            if (stream && cnt_ff == 5'd0) begin
               state_in = aesbm_pkg::ST_FINISH;
            end else begin
               state_in = aesbm_pkg::ST_ROUND;
            end
         end
         aesbm_pkg::ST_ROUND: begin
            st_in  = round_out;
            rnd_in = 4'(rnd_ff + 4'd1);
            if (rnd_ff == aesbm_pkg::LAST_ROUND) begin
               state_in = aesbm_pkg::ST_FINISH;
            end
         end
         aesbm_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = 1'b0;
               rsp_end_in   = 1'b1;
               state_in     = aesbm_pkg::ST_IDLE;
               if (blk_mode_enc) begin
                  rsp_data_in  = st_ff;
                  rsp_count_in = aesbm_pkg::FULL_COUNT;
                  if (mode_ff == aesbm_pkg::MODE_CBC) begin
                     chain_in = st_ff;
                  end
                  if (last_ff && cnt_ff == aesbm_pkg::FULL_COUNT && !pass2_ff) begin
                     pass2_in   = 1'b1;
                     rsp_end_in = 1'b0;
                     state_in   = aesbm_pkg::ST_LOAD;
                  end
               end else if (aes_dec) begin
                  rsp_count_in = aesbm_pkg::FULL_COUNT;
                  if (mode_ff == aesbm_pkg::MODE_CBC) begin
                     chain_in = data_ff;
                  end
                  if (last_ff) begin
                     if (pad_len > 8'd16) begin
                        rsp_count_in = 5'd0;
                        rsp_err_in   = 1'b1;
                     end else begin
                        rsp_count_in = 5'(aesbm_pkg::FULL_COUNT - pad_len[4:0]);
                     end
                  end
                  rsp_data_in = fin_b & aesbm_pkg::byte_mask(rsp_count_in);
               end else if (cnt_ff == 5'd0) begin
                  rsp_data_in  = '0;
                  rsp_count_in = 5'd0;
               end else begin
                  rsp_data_in  = (st_ff ^ dm) & dmask;
                  rsp_count_in = cnt_ff;
                  case (mode_ff)
                     aesbm_pkg::MODE_OFB: chain_in = st_ff;
                     aesbm_pkg::MODE_CFB: chain_in = dec_ff ? dm : ((st_ff ^ dm) & dmask);
                     aesbm_pkg::MODE_CTR: chain_in = {chain_ff[127:64], 64'(chain_ff[63:0] + 64'd1)};
                     default: chain_in = chain_ff;
                  endcase
               end
            end
         end
         default: begin
            state_in = aesbm_pkg::ST_IDLE;
         end
      endcase

      if (csr_write_enable &&
          (csr_index == aesbm_pkg::CSR_KEY_HIGH || csr_index == aesbm_pkg::CSR_KEY_LOW)) begin
         keys_ready_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= aesbm_pkg::ST_IDLE;
         keys_ready_ff <= 1'b0;
         chain_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         key_ff        <= '0;
         iv_ff         <= '0;
         mode_reg_ff   <= aesbm_pkg::MODE_ECB;
         dec_reg_ff    <= 1'b0;
         pass2_ff      <= 1'b0;
         rnd_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         keys_ready_ff <= keys_ready_in;
         chain_ff      <= chain_in;
         rsp_valid_ff  <= rsp_valid_in;
         pass2_ff      <= pass2_in;
         rnd_ff        <= rnd_in;
         if (csr_write_enable) begin
            case (csr_index)
               aesbm_pkg::CSR_KEY_HIGH:    key_ff[127:64] <= csr_wdata;
               aesbm_pkg::CSR_KEY_LOW:     key_ff[63:0]   <= csr_wdata;
               aesbm_pkg::CSR_IV_HIGH:     iv_ff[127:64]  <= csr_wdata;
               aesbm_pkg::CSR_IV_LOW:      iv_ff[63:0]    <= csr_wdata;
               aesbm_pkg::CSR_BLOCK_MODE:  mode_reg_ff    <= csr_wdata[2:0];
               aesbm_pkg::CSR_DECRYPT_SEL: dec_reg_ff     <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   // payload and round key storage
   always_ff @(posedge clock) begin
      kexp_ff      <= kexp_in;
      rcon_ff      <= rcon_in;
      st_ff        <= st_in;
      data_ff      <= data_in;
      cnt_ff       <= cnt_in;
      last_ff      <= last_in;
      mode_ff      <= mode_in;
      dec_ff       <= dec_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_count_ff <= rsp_count_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_err_ff   <= rsp_err_in;
      if (state_ff == aesbm_pkg::ST_IDLE && req_xfer && !keys_ready_ff) begin
         rk_ff[0] <= key_ff;
      end
      if (state_ff == aesbm_pkg::ST_EXPAND) begin
         rk_ff[rnd_ff] <= kexp_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_high   = rsp_data_ff[127:64];
   assign rsp_out_low    = rsp_data_ff[63:0];
   assign rsp_out_count  = rsp_count_ff;
   assign rsp_end_of_run = rsp_end_ff;
   assign rsp_pad_error  = rsp_err_ff;

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == aesbm_pkg::ST_ROUND |-> rnd_ff >= 4'd1 && rnd_ff <= aesbm_pkg::LAST_ROUND)
      else $error("round counter out of range");

   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff != aesbm_pkg::ST_IDLE)
      else $error("engine idle after input transfer");

   a_keys_after_expand: assert property (@(posedge clock) disable iff (reset)
      state_ff == aesbm_pkg::ST_EXPAND && rnd_ff == aesbm_pkg::LAST_ROUND && !csr_write_enable
      |=> keys_ready_ff)
      else $error("keys not ready after schedule");

   a_err_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> rsp_count_ff == 5'd0 && rsp_end_ff)
      else $error("pad error with nonzero count");

endmodule
